// ===== rtl/bqe_pkg.sv =====
// ----------------------------------------------------------------------------
// bqe_pkg
// Types, stage map and constants shared by the billboard quad expander.
// ----------------------------------------------------------------------------
package bqe_pkg;

  localparam int unsigned ColorDepth = 12;

  localparam logic [16:0] T_ONE       = 17'h10000;
  localparam logic [31:0] COLOR_RESET = 32'hFF80_8080;
  localparam logic [47:0] RIGHT_RESET = 48'h0000_0000_4000;
  localparam logic [47:0] UP_RESET    = 48'h0000_4000_0000;

  // pipeline stage map
  localparam int unsigned ST_SETUP      = 1;
  localparam int unsigned ST_DIV1_FIRST = 2;
  localparam int unsigned ST_DIV1_LAST  = 9;
  localparam int unsigned ST_T          = 10;
  localparam int unsigned ST_DIV2_FIRST = 11;
  localparam int unsigned ST_DIV2_LAST  = 18;
  localparam int unsigned ST_SIZE_MUL   = 11;
  localparam int unsigned ST_SIZE_SUM   = 12;
  localparam int unsigned ST_OFS_MUL    = 13;
  localparam int unsigned ST_VERT       = 14;
  localparam int unsigned ST_CT         = 19;
  localparam int unsigned ST_TAB        = 20;
  localparam int unsigned ST_CMUL       = 21;
  localparam int unsigned ST_CMIX       = 22;
  localparam int unsigned NumStages     = 23;

  typedef enum logic [2:0] {
    REG_EMITTER_X = 3'd0,
    REG_EMITTER_Y = 3'd1,
    REG_EMITTER_Z = 3'd2,
    REG_RIGHT     = 3'd3,
    REG_UP        = 3'd4,
    REG_MID_EN    = 3'd5,
    REG_MID_TIME  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BLEND_DIRECT    = 2'd0,
    BLEND_START_MID = 2'd1,
    BLEND_MID_END   = 2'd2
  } blend_e;

  typedef enum logic [1:0] {
    CORNER_LT = 2'd0,
    CORNER_RT = 2'd1,
    CORNER_RB = 2'd2,
    CORNER_LB = 2'd3
  } corner_e;

  typedef struct packed {
    logic                   req;
    logic [3:0]             cidx;
    logic [31:0]            cword;
    logic [31:0]            age;
    logic [31:0]            life;
    logic [31:0]            sw;
    logic [31:0]            ew;
    logic [31:0]            sh;
    logic [31:0]            eh;
    logic [2:0][31:0]       lpos;
    logic [2:0][31:0]       pos;
    logic                   sat;
    logic [31:0]            r1;
    logic [15:0]            q1;
    logic [16:0]            t;
    blend_e                 blend;
    logic [16:0]            r2;
    logic [16:0]            d2;
    logic [16:0]            q2;
    logic [48:0]            ws_p;
    logic [48:0]            we_p;
    logic [48:0]            hs_p;
    logic [48:0]            he_p;
    logic [31:0]            w;
    logic [31:0]            h;
    logic [2:0][48:0]       rp;
    logic [2:0][48:0]       up;
    logic [3:0][2:0][31:0]  vert;
    logic [16:0]            ct;
    logic [3:0][31:0]       ca;
    logic [3:0][31:0]       cb;
    logic [3:0][3:0]        cdir;
    logic [3:0][3:0][24:0]  cprod;
    logic [3:0][31:0]       col;
  } item_t;

endpackage

// ===== rtl/bqe_if.sv =====
// ----------------------------------------------------------------------------
// bqe_in_if / bqe_out_if / bqe_cfg_if
// Valid/ready channels of the billboard quad expander.
// ----------------------------------------------------------------------------
interface bqe_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [31:0]        age;
  logic [31:0]        lifetime;
  logic [31:0]        start_width;
  logic [31:0]        end_width;
  logic [31:0]        start_height;
  logic [31:0]        end_height;
  logic signed [31:0] local_x;
  logic signed [31:0] local_y;
  logic signed [31:0] local_z;
  logic [3:0]         color_index;
  logic [31:0]        color_word;

  modport source (output valid, req_type, age, lifetime, start_width, end_width,
                  start_height, end_height, local_x, local_y, local_z,
                  color_index, color_word, input ready);
  modport sink   (input valid, req_type, age, lifetime, start_width, end_width,
                  start_height, end_height, local_x, local_y, local_z,
                  color_index, color_word, output ready);
endinterface

interface bqe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic [7:0]         color_red;
  logic [7:0]         color_green;
  logic [7:0]         color_blue;
  logic [7:0]         color_alpha;
  logic               tex_u;
  logic               tex_v;
  logic               last_vertex;

  modport source (output valid, vert_x, vert_y, vert_z, color_red, color_green,
                  color_blue, color_alpha, tex_u, tex_v, last_vertex, input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, color_red, color_green,
                  color_blue, color_alpha, tex_u, tex_v, last_vertex, output ready);
endinterface

interface bqe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/billboard_quad_expander_unit.sv =====
// An accepted particle passes the stage registers p_q and then ex_q before its first
// corner is on the output; the serialiser holds the pipeline until all four corners
//   are taken. Colour items are taken one per cycle unless stalled; they yield no result.
// The two dividers are pipelined two quotient bits per stage.
// Reset: valid bits, config registers and the 12-word colour table take their
//   reset values at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// billboard_quad_expander_unit
// Expands particles into four billboard corner vertices with blended colours.
// ----------------------------------------------------------------------------
module billboard_quad_expander_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  bqe_in_if.sink    in_if,
  bqe_out_if.source out_if,
  bqe_cfg_if.sink   cfg_if
);

  localparam int unsigned NS = bqe_pkg::NumStages;

  logic [2:0][31:0] emit_q;
  logic [47:0]      right_q;
  logic [47:0]      up_q;
  logic             mid_en_q;
  logic [15:0]      mid_time_q;
  logic [31:0]      tab_q [bqe_pkg::ColorDepth];

  bqe_pkg::item_t p_q [NS];
  bqe_pkg::item_t nxt [NS];
  logic [NS-1:0]  v_q;
  logic [NS:0]    en;

  bqe_pkg::item_t ex_q;
  logic           ex_v_q;
  logic [1:0]     corner_q;
  logic           ex_en;
  logic           out_xfer;
  logic           tab_we;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q     <= '0;
      right_q    <= bqe_pkg::RIGHT_RESET;
      up_q       <= bqe_pkg::UP_RESET;
      mid_en_q   <= 1'b0;
      mid_time_q <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        bqe_pkg::REG_EMITTER_X: emit_q[0]  <= cfg_if.data[31:0];
        bqe_pkg::REG_EMITTER_Y: emit_q[1]  <= cfg_if.data[31:0];
        bqe_pkg::REG_EMITTER_Z: emit_q[2]  <= cfg_if.data[31:0];
        bqe_pkg::REG_RIGHT:     right_q    <= cfg_if.data;
        bqe_pkg::REG_UP:        up_q       <= cfg_if.data;
        bqe_pkg::REG_MID_EN:    mid_en_q   <= cfg_if.data[0];
        bqe_pkg::REG_MID_TIME:  mid_time_q <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  // stall chain: a stage loads when empty or when its successor loads
  assign out_xfer = ex_v_q && out_if.ready;
  assign ex_en    = !ex_v_q || (out_if.ready && corner_q == bqe_pkg::CORNER_LB);

  always_comb begin
    en[NS] = ex_en;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_if.ready = en[0];

  // colour writes land as the item enters the blend-factor stage
  assign tab_we = en[bqe_pkg::ST_CT] && v_q[bqe_pkg::ST_CT-1] && p_q[bqe_pkg::ST_CT-1].req
                  && (p_q[bqe_pkg::ST_CT-1].cidx < 4'(bqe_pkg::ColorDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bqe_pkg::ColorDepth; i++) tab_q[i] <= bqe_pkg::COLOR_RESET;
    end else if (tab_we) begin
      tab_q[p_q[bqe_pkg::ST_CT-1].cidx] <= p_q[bqe_pkg::ST_CT-1].cword;
    end
  end

  // stage 0 capture and per-stage work
  always_comb begin
    logic [32:0] rr1;
    logic [17:0] rr2;
    logic [16:0] n2;
    logic [48:0] sum_w;
    logic [48:0] sum_h;
    logic [31:0] ro;
    logic [31:0] uo;
    logic [7:0]  cs;
    logic [7:0]  ce;
    logic [7:0]  diff;
    nxt[0]          = '0;
    nxt[0].req      = in_if.req_type;
    nxt[0].cidx     = in_if.color_index;
    nxt[0].cword    = in_if.color_word;
    nxt[0].age      = in_if.age;
    nxt[0].life     = in_if.lifetime;
    nxt[0].sw       = in_if.start_width;
    nxt[0].ew       = in_if.end_width;
    nxt[0].sh       = in_if.start_height;
    nxt[0].eh       = in_if.end_height;
    nxt[0].lpos[0]  = in_if.local_x;
    nxt[0].lpos[1]  = in_if.local_y;
    nxt[0].lpos[2]  = in_if.local_z;
    for (int k = 1; k < NS; k++) begin
      nxt[k] = p_q[k-1];
      rr1 = '0; rr2 = '0; n2 = '0; sum_w = '0; sum_h = '0;
      ro = '0; uo = '0; cs = '0; ce = '0; diff = '0;

      if (k == bqe_pkg::ST_SETUP) begin
        for (int a = 0; a < 3; a++) nxt[k].pos[a] = p_q[k-1].lpos[a] + emit_q[a];
        nxt[k].sat = (p_q[k-1].life == '0) || (p_q[k-1].age >= p_q[k-1].life);
        nxt[k].r1  = p_q[k-1].age;
        nxt[k].q1  = '0;
      end

      if (k >= bqe_pkg::ST_DIV1_FIRST && k <= bqe_pkg::ST_DIV1_LAST) begin
        for (int s = 0; s < 2; s++) begin
          rr1 = {nxt[k].r1, 1'b0};
          if (rr1 >= {1'b0, nxt[k].life}) begin
            rr1        = rr1 - {1'b0, nxt[k].life};
            nxt[k].q1  = {nxt[k].q1[14:0], 1'b1};
          end else begin
            nxt[k].q1  = {nxt[k].q1[14:0], 1'b0};
          end
          nxt[k].r1 = rr1[31:0];
        end
      end

      if (k == bqe_pkg::ST_T) begin
        nxt[k].t = p_q[k-1].sat ? bqe_pkg::T_ONE : {1'b0, p_q[k-1].q1};
        if (!mid_en_q) begin
          nxt[k].blend = bqe_pkg::BLEND_DIRECT;
          n2           = '0;
          nxt[k].d2    = 17'd1;
        end else if (nxt[k].t < {1'b0, mid_time_q}) begin
          nxt[k].blend = bqe_pkg::BLEND_START_MID;
          n2           = nxt[k].t;
          nxt[k].d2    = {1'b0, mid_time_q};
        end else begin
          nxt[k].blend = bqe_pkg::BLEND_MID_END;
          n2           = nxt[k].t - {1'b0, mid_time_q};
          nxt[k].d2    = bqe_pkg::T_ONE - {1'b0, mid_time_q};
        end
        // the mid-to-end quotient can reach one exactly
        if (n2 >= nxt[k].d2) begin
          nxt[k].q2 = 17'd1;
          nxt[k].r2 = n2 - nxt[k].d2;
        end else begin
          nxt[k].q2 = '0;
          nxt[k].r2 = n2;
        end
      end

      if (k >= bqe_pkg::ST_DIV2_FIRST && k <= bqe_pkg::ST_DIV2_LAST) begin
        for (int s = 0; s < 2; s++) begin
          rr2 = {nxt[k].r2, 1'b0};
          if (rr2 >= {1'b0, nxt[k].d2}) begin
            rr2        = rr2 - {1'b0, nxt[k].d2};
            nxt[k].q2  = {nxt[k].q2[15:0], 1'b1};
          end else begin
            nxt[k].q2  = {nxt[k].q2[15:0], 1'b0};
          end
          nxt[k].r2 = rr2[16:0];
        end
      end

      if (k == bqe_pkg::ST_SIZE_MUL) begin
        nxt[k].ws_p = 49'(p_q[k-1].sw) * 49'(bqe_pkg::T_ONE - p_q[k-1].t);
        nxt[k].we_p = 49'(p_q[k-1].ew) * 49'(p_q[k-1].t);
        nxt[k].hs_p = 49'(p_q[k-1].sh) * 49'(bqe_pkg::T_ONE - p_q[k-1].t);
        nxt[k].he_p = 49'(p_q[k-1].eh) * 49'(p_q[k-1].t);
      end

      if (k == bqe_pkg::ST_SIZE_SUM) begin
        sum_w    = p_q[k-1].ws_p + p_q[k-1].we_p;
        sum_h    = p_q[k-1].hs_p + p_q[k-1].he_p;
        nxt[k].w = sum_w[47:16];
        nxt[k].h = sum_h[47:16];
      end

      if (k == bqe_pkg::ST_OFS_MUL) begin
        for (int a = 0; a < 3; a++) begin
          nxt[k].rp[a] = $signed(right_q[16*a +: 16]) * $signed({1'b0, p_q[k-1].w});
          nxt[k].up[a] = $signed(up_q[16*a +: 16]) * $signed({1'b0, p_q[k-1].h});
        end
      end

      if (k == bqe_pkg::ST_VERT) begin
        for (int a = 0; a < 3; a++) begin
          // floor shift by 14, kept to the wrapping 32 bits
          ro = p_q[k-1].rp[a][45:14];
          uo = p_q[k-1].up[a][45:14];
          nxt[k].vert[bqe_pkg::CORNER_LT][a] = p_q[k-1].pos[a] - ro + uo;
          nxt[k].vert[bqe_pkg::CORNER_RT][a] = p_q[k-1].pos[a] + ro + uo;
          nxt[k].vert[bqe_pkg::CORNER_RB][a] = p_q[k-1].pos[a] + ro - uo;
          nxt[k].vert[bqe_pkg::CORNER_LB][a] = p_q[k-1].pos[a] - ro - uo;
        end
      end

      if (k == bqe_pkg::ST_CT) begin
        nxt[k].ct = (p_q[k-1].blend == bqe_pkg::BLEND_DIRECT) ? p_q[k-1].t : p_q[k-1].q2;
      end

      if (k == bqe_pkg::ST_TAB) begin
        for (int c = 0; c < 4; c++) begin
          case (p_q[k-1].blend)
            bqe_pkg::BLEND_START_MID: begin
              nxt[k].ca[c] = tab_q[c];
              nxt[k].cb[c] = tab_q[4+c];
            end
            bqe_pkg::BLEND_MID_END: begin
              nxt[k].ca[c] = tab_q[4+c];
              nxt[k].cb[c] = tab_q[8+c];
            end
            default: begin
              nxt[k].ca[c] = tab_q[c];
              nxt[k].cb[c] = tab_q[8+c];
            end
          endcase
        end
      end

      if (k == bqe_pkg::ST_CMUL) begin
        for (int c = 0; c < 4; c++) begin
          for (int j = 0; j < 4; j++) begin
            cs   = p_q[k-1].ca[c][8*j +: 8];
            ce   = p_q[k-1].cb[c][8*j +: 8];
            nxt[k].cdir[c][j] = (ce >= cs);
            diff = (ce >= cs) ? (ce - cs) : (cs - ce);
            nxt[k].cprod[c][j] = 25'(diff) * 25'(p_q[k-1].ct);
          end
        end
      end

      if (k == bqe_pkg::ST_CMIX) begin
        for (int c = 0; c < 4; c++) begin
          for (int j = 0; j < 4; j++) begin
            cs = p_q[k-1].ca[c][8*j +: 8];
            nxt[k].col[c][8*j +: 8] = p_q[k-1].cdir[c][j]
                                    ? cs + p_q[k-1].cprod[c][j][23:16]
                                    : cs - p_q[k-1].cprod[c][j][23:16];
          end
        end
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_if.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          // colour items have done their write: drop them here
          if (k == bqe_pkg::ST_TAB) v_q[k] <= v_q[k-1] && !p_q[k-1].req;
          else                      v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) p_q[k] <= nxt[k];
    end
  end

  // corner serialiser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q   <= 1'b0;
      corner_q <= bqe_pkg::CORNER_LT;
    end else if (ex_en) begin
      ex_v_q   <= v_q[NS-1];
      corner_q <= bqe_pkg::CORNER_LT;
    end else if (out_xfer) begin
      corner_q <= corner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_en) ex_q <= p_q[NS-1];
  end

  assign out_if.valid       = ex_v_q;
  assign out_if.vert_x      = ex_q.vert[corner_q][0];
  assign out_if.vert_y      = ex_q.vert[corner_q][1];
  assign out_if.vert_z      = ex_q.vert[corner_q][2];
  assign out_if.color_red   = ex_q.col[corner_q][7:0];
  assign out_if.color_green = ex_q.col[corner_q][15:8];
  assign out_if.color_blue  = ex_q.col[corner_q][23:16];
  assign out_if.color_alpha = ex_q.col[corner_q][31:24];
  assign out_if.tex_u       = (corner_q == bqe_pkg::CORNER_RT) ||
                              (corner_q == bqe_pkg::CORNER_RB);
  assign out_if.tex_v       = corner_q[1];
  assign out_if.last_vertex = (corner_q == bqe_pkg::CORNER_LB);

endmodule

// ===== rtl/bqe_checker.sv =====
// ----------------------------------------------------------------------------
// bqe_checker
// Port-level checks on the corner stream of the billboard quad expander.
// ----------------------------------------------------------------------------
module bqe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic tex_u_i,
  input logic tex_v_i,
  input logic last_vertex_i
);

  // a stalled corner stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("corner withdrawn while stalled");

  // the remaining corners of a quad follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_vertex_i) |=> out_valid_i)
    else $error("gap inside a quad");

  // first corner is followed by the top right one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !tex_u_i && !tex_v_i)
      |=> (tex_u_i && !tex_v_i && !last_vertex_i))
    else $error("corner order broken");

  // the closing corner carries texture (0,1)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && last_vertex_i) |-> (!tex_u_i && tex_v_i))
    else $error("last flag on wrong corner");

endmodule

bind billboard_quad_expander_unit bqe_checker u_bqe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .tex_u_i       (out_if.tex_u),
  .tex_v_i       (out_if.tex_v),
  .last_vertex_i (out_if.last_vertex)
);
